// ===== src/signed_binary_to_decimal_ascii_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for signed_binary_to_decimal_ascii
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define SBDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// The condition must never be seen at a clock edge outside reset.
`define SBDA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SBDA_ASSERT(lbl, prop, msg)
`define SBDA_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== src/sbda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared constants, types and helper functions of the decimal text converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int ValueW      = 64;
  localparam int DigitW      = 4;
  localparam int NumDigits   = 20;
  localparam int BcdW        = NumDigits * DigitW;
  localparam int DigitIdxW   = $clog2(NumDigits);
  localparam int BitsPerStep = 4;
  localparam int StepCnt     = ValueW / BitsPerStep;
  localparam int StepCntW    = $clog2(StepCnt);
  localparam int CharW       = 7;
  localparam int QDepth      = 2;
  localparam int QPtrW       = $clog2(QDepth);
  localparam int QCntW       = $clog2(QDepth + 1);

  localparam logic [CharW-1:0]  CHAR_ZERO  = 7'd48;
  localparam logic [CharW-1:0]  CHAR_MINUS = 7'd45;
  localparam logic [DigitW-1:0] DIGIT_MAX  = 4'd9;

  typedef logic [NumDigits-1:0][DigitW-1:0] bcd_t;

  // One number after classification: sign and unsigned magnitude.
  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
  } item_t;

  // One number after conversion, ready to be spelt out.
  typedef struct packed {
    logic neg;
    bcd_t bcd;
  } conv_res_t;

  // One shift-and-add-three step of binary to BCD conversion.
  function automatic bcd_t dabble_step(input bcd_t bcd, input logic bit_in);
    bcd_t            adj;
    logic [BcdW-1:0] flat;
    adj = bcd;
    for (int d = 0; d < NumDigits; d++) begin
      if (adj[d] >= DigitW'(5)) begin
        adj[d] = adj[d] + DigitW'(3);
      end
    end
    flat = adj;
    return bcd_t'({flat[BcdW-2:0], bit_in});
  endfunction

  // Position of the most significant non-zero digit; zero for a zero value.
  function automatic logic [DigitIdxW-1:0] lead_index(input bcd_t bcd);
    logic [DigitIdxW-1:0] idx;
    idx = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd[d] != '0) begin
        idx = DigitIdxW'(d);
      end
    end
    return idx;
  endfunction

endpackage

// ===== src/signed_binary_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Signed 64-bit integer to decimal ASCII text, one character per beat.
// ----------------------------------------------------------------------------
//  Channel  | Handshake         | Payload
//  ---------+-------------------+-----------------------------
//  input    | push_i / full_o   | value_i (64-bit signed)
//  result   | pop_i  / empty_o  | char_code_o (7 bits), last_o
//
// Conversion moves four magnitude bits per cycle through the shift-and-add-three
// unit, then hands the result over, then spells it out one character
// per cycle while pop_i is held: up to 20 for the most negative value.
// Conversion of the next number overlaps spelling of the current one, so a
// new number is converted while the one before it is still being spelt out.
// Reset is asynchronous and clears the queue and both state machines only.
// A stalled result side fills the two-entry queue and then raises full_o.
// ----------------------------------------------------------------------------
`include "signed_binary_to_decimal_ascii_assert.svh"

module signed_binary_to_decimal_ascii (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic signed [63:0]          value_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [6:0]                  char_code_o,
  output logic                        last_o
);

  logic                  q_valid, q_ready;
  sbda_pkg::item_t       q_item;
  logic                  c_valid, c_ready;
  sbda_pkg::conv_res_t   c_res;

  sbda_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .value_i   (value_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  sbda_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_item_i   (q_item),
    .out_valid_o (c_valid),
    .out_ready_i (c_ready),
    .out_res_o   (c_res)
  );

  sbda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c_valid),
    .in_ready_o  (c_ready),
    .in_res_i    (c_res),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  // A minus sign is never the whole text.
  `SBDA_ASSERT_NEVER(a_minus_not_last, !empty_o && (char_code_o == sbda_pkg::CHAR_MINUS) && last_o, "minus sign flagged as last character")

  // Every character is a minus sign or a decimal digit.
  `SBDA_ASSERT(a_char_range, !empty_o |-> ((char_code_o == sbda_pkg::CHAR_MINUS) || ((char_code_o >= sbda_pkg::CHAR_ZERO) && (char_code_o <= (sbda_pkg::CHAR_ZERO + 7'(sbda_pkg::DIGIT_MAX))))), "character outside sign and digits")

  // Digits follow a taken minus sign at once.
  `SBDA_ASSERT(a_digit_after_minus, (pop_i && !empty_o && (char_code_o == sbda_pkg::CHAR_MINUS)) |=> (!empty_o && (char_code_o != sbda_pkg::CHAR_MINUS)), "no digit after minus sign")

endmodule

// ===== src/sbda_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_front
// Accepts numbers, splits them into sign and magnitude and queues them.
// ----------------------------------------------------------------------------
module sbda_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic [sbda_pkg::ValueW-1:0] value_i,
  output logic                       q_valid_o,
  input  logic                       q_ready_i,
  output sbda_pkg::item_t            q_item_o
);

  sbda_pkg::item_t                   mem_q [sbda_pkg::QDepth];
  logic [sbda_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [sbda_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [sbda_pkg::QCntW-1:0]        cnt_q, cnt_d;
  logic                              wr_en, rd_en;
  sbda_pkg::item_t                   new_item;

  assign full_o    = (cnt_q == sbda_pkg::QCntW'(sbda_pkg::QDepth));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];
  assign wr_en     = push_i && !full_o;
  assign rd_en     = q_valid_o && q_ready_i;

  // The most negative value negates onto itself, which read unsigned is its magnitude.
  assign new_item.neg = value_i[sbda_pkg::ValueW-1];
  assign new_item.mag = value_i[sbda_pkg::ValueW-1] ? (~value_i + 1'b1) : value_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == sbda_pkg::QPtrW'(sbda_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == sbda_pkg::QPtrW'(sbda_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ===== src/sbda_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_conv
// Binary to BCD converter, shift-and-add-three, BitsPerStep bits per cycle.
// ----------------------------------------------------------------------------
module sbda_conv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sbda_pkg::item_t       in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sbda_pkg::conv_res_t   out_res_o
);

  typedef enum logic [2:0] {
    CONV_IDLE = 3'b001,
    CONV_RUN  = 3'b010,
    CONV_DONE = 3'b100
  } conv_state_e;

  conv_state_e                      state_q, state_d;
  logic [sbda_pkg::StepCntW-1:0]    cnt_q, cnt_d;
  logic [sbda_pkg::ValueW-1:0]      shift_q, shift_d;
  sbda_pkg::bcd_t                   bcd_q, bcd_d;
  logic                             neg_q, neg_d;
  sbda_pkg::bcd_t                   bcd_step;
  logic [sbda_pkg::ValueW-1:0]      shift_step;

  assign in_ready_o      = (state_q == CONV_IDLE);
  assign out_valid_o     = (state_q == CONV_DONE);
  assign out_res_o.neg   = neg_q;
  assign out_res_o.bcd   = bcd_q;

  // Each cycle moves BitsPerStep magnitude bits, most significant first, into the BCD word.
  always_comb begin
    bcd_step   = bcd_q;
    shift_step = shift_q;
    for (int s = 0; s < sbda_pkg::BitsPerStep; s++) begin
      bcd_step   = sbda_pkg::dabble_step(bcd_step, shift_step[sbda_pkg::ValueW-1]);
      shift_step = {shift_step[sbda_pkg::ValueW-2:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    case (state_q)
      CONV_IDLE: begin
        if (in_valid_i) begin
          state_d = CONV_RUN;
          cnt_d   = '0;
          shift_d = in_item_i.mag;
          bcd_d   = '0;
          neg_d   = in_item_i.neg;
        end
      end
      CONV_RUN: begin
        shift_d = shift_step;
        bcd_d   = bcd_step;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == sbda_pkg::StepCntW'(sbda_pkg::StepCnt - 1)) begin
          state_d = CONV_DONE;
        end
      end
      CONV_DONE: begin
        if (out_ready_i) begin
          state_d = CONV_IDLE;
        end
      end
      default: begin
        state_d = CONV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CONV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
    neg_q   <= neg_d;
  end

endmodule

// ===== src/sbda_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_emit
// Spells out one converted number as ASCII characters, one per beat.
// ----------------------------------------------------------------------------
module sbda_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  sbda_pkg::conv_res_t        in_res_i,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [sbda_pkg::CharW-1:0] char_code_o,
  output logic                       last_o
);

  typedef enum logic [2:0] {
    EMIT_IDLE  = 3'b001,
    EMIT_SIGN  = 3'b010,
    EMIT_DIGIT = 3'b100
  } emit_state_e;

  emit_state_e                       state_q, state_d;
  logic [sbda_pkg::DigitIdxW-1:0]    idx_q, idx_d;
  sbda_pkg::bcd_t                    bcd_q, bcd_d;
  logic                              beat;

  assign in_ready_o = (state_q == EMIT_IDLE);
  assign empty_o    = (state_q == EMIT_IDLE);
  assign beat       = pop_i && !empty_o;

  assign char_code_o = (state_q == EMIT_SIGN) ? sbda_pkg::CHAR_MINUS
                     : sbda_pkg::CHAR_ZERO + {{(sbda_pkg::CharW - sbda_pkg::DigitW){1'b0}},
                                              bcd_q[idx_q]};
  assign last_o      = (state_q == EMIT_DIGIT) && (idx_q == '0);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    bcd_d   = bcd_q;
    case (state_q)
      EMIT_IDLE: begin
        if (in_valid_i) begin
          // Leading zeros are skipped by starting at the top non-zero digit.
          state_d = in_res_i.neg ? EMIT_SIGN : EMIT_DIGIT;
          idx_d   = sbda_pkg::lead_index(in_res_i.bcd);
          bcd_d   = in_res_i.bcd;
        end
      end
      EMIT_SIGN: begin
        if (beat) begin
          state_d = EMIT_DIGIT;
        end
      end
      EMIT_DIGIT: begin
        if (beat) begin
          if (idx_q == '0) begin
            state_d = EMIT_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = EMIT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EMIT_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for signed_binary_to_decimal_ascii
// Pushes signed 64-bit numbers into the converter and checks every character
// beat against an independent decimal spelling of the same number. Both
// sides idle at random, the result side stalls for a long stretch so that
// the input side fills up, and the sender pauses twice until the converter
// has drained completely.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          HalfPeriod = 4;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned IdlePct    = 30;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned HoldAfter  = 60;
  localparam int unsigned RandomNums = 260;
  localparam logic [sbda_pkg::ValueW-1:0] Radix = 64'd10;

  typedef struct {
    logic signed [sbda_pkg::ValueW-1:0] value;
    logic                               wait_drain;
  } number_t;

  typedef struct {
    logic [sbda_pkg::CharW-1:0] code;
    logic                       is_last;
  } char_beat_t;

  logic                               clk_i   = 1'b0;
  logic                               rst_ni  = 1'b0;
  logic                               push_i  = 1'b0;
  logic                               pop_i   = 1'b0;
  logic signed [sbda_pkg::ValueW-1:0] value_i = '0;
  logic                               full_o;
  logic                               empty_o;
  logic [sbda_pkg::CharW-1:0]         char_code_o;
  logic                               last_o;

  number_t    numbers_q[$];
  char_beat_t text_q[$];

  int unsigned cyc          = 0;
  int unsigned err_cnt      = 0;
  int unsigned taken_cnt    = 0;
  int unsigned char_cnt     = 0;
  int unsigned neg_cnt      = 0;
  int unsigned longest_text = 0;
  int unsigned full_cycles  = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  signed_binary_to_decimal_ascii dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .value_i    (value_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .char_code_o(char_code_o),
    .last_o     (last_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // A window in which neither side idles at random.
  function automatic bit calm_window();
    return cyc >= 1500 && cyc < 3000;
  endfunction

  // Expected text of one number: optional minus, then digits, most
  // significant first, with the last flag on the final character.
  function automatic int unsigned spell_decimal(
    input logic signed [sbda_pkg::ValueW-1:0] num
  );
    logic [sbda_pkg::ValueW-1:0] mag;
    logic [3:0]                  digits[sbda_pkg::NumDigits];
    int unsigned                 ndig;
    char_beat_t                  beat;
    int unsigned                 len;
    mag  = num[sbda_pkg::ValueW-1] ? (~num + 64'd1) : num;
    ndig = 0;
    len  = 0;
    do begin
      digits[ndig] = 4'(mag % Radix);
      mag          = mag / Radix;
      ndig++;
    end while (mag != '0 && ndig < sbda_pkg::NumDigits);
    if (num[sbda_pkg::ValueW-1]) begin
      beat.code    = sbda_pkg::CHAR_MINUS;
      beat.is_last = 1'b0;
      text_q.push_back(beat);
      len++;
    end
    for (int i = int'(ndig) - 1; i >= 0; i--) begin
      beat.code    = sbda_pkg::CHAR_ZERO + sbda_pkg::CharW'(digits[i]);
      beat.is_last = (i == 0);
      text_q.push_back(beat);
      len++;
    end
    return len;
  endfunction

  function automatic logic [sbda_pkg::ValueW-1:0] pow10(input int unsigned k);
    logic [sbda_pkg::ValueW-1:0] p;
    p = 64'd1;
    repeat (k) p = p * Radix;
    return p;
  endfunction

  function automatic logic signed [sbda_pkg::ValueW-1:0] random_number();
    logic [sbda_pkg::ValueW-1:0] raw;
    logic [sbda_pkg::ValueW-1:0] mag;
    int unsigned                 k;
    raw = {$urandom, $urandom};
    k   = $urandom_range(18, 1);
    case ($urandom_range(5, 0))
      0, 1: mag = raw;
      2:    mag = raw >> $urandom_range(63, 1);
      3:    mag = pow10(k) - 64'($urandom_range(1, 0));
      4:    mag = {1'b0, {63{1'b1}}} - 64'($urandom_range(3, 0));
      default: mag = raw % pow10(k);
    endcase
    if (mag[sbda_pkg::ValueW-1]) begin
      return mag;
    end
    return $urandom_range(1, 0) ? -mag : mag;
  endfunction

  task automatic add_number(input logic signed [sbda_pkg::ValueW-1:0] num,
                            input logic wait_drain);
    number_t n;
    n.value      = num;
    n.wait_drain = wait_drain;
    numbers_q.push_back(n);
  endtask

  // Sender: offers the oldest pending number, or idles.
  always @(negedge clk_i) begin
    if (!rst_ni || numbers_q.size() == 0) begin
      push_i <= 1'b0;
    end else if (numbers_q[0].wait_drain && text_q.size() != 0) begin
      push_i <= 1'b0;
    end else if (!calm_window() && $urandom_range(99, 0) < IdlePct) begin
      push_i <= 1'b0;
    end else begin
      push_i  <= 1'b1;
      value_i <= numbers_q[0].value;
    end
  end

  // Receiver: random pops, with one long hold-off once traffic is flowing.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else if (hold_left != 0) begin
      pop_i     <= 1'b0;
      hold_left = hold_left - 1;
    end else if (!hold_done && taken_cnt >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      pop_i     <= 1'b0;
    end else begin
      pop_i <= calm_window() || $urandom_range(99, 0) >= IdlePct;
    end
  end

  // Monitor: records accepted numbers and checks every character beat.
  always @(posedge clk_i) begin
    char_beat_t  want;
    int unsigned len;
    cyc++;
    if (cyc >= CycleLimit) begin
      $display("signed_binary_to_decimal_ascii test failed");
      $finish;
    end else if (rst_ni) begin
      if (push_i && full_o) begin
        full_cycles++;
      end
      if (push_i && !full_o) begin
        len = spell_decimal(value_i);
        if (len > longest_text) begin
          longest_text = len;
        end
        if (value_i < 0) begin
          neg_cnt++;
        end
        taken_cnt++;
        void'(numbers_q.pop_front());
      end
      if (pop_i && !empty_o) begin
        char_cnt++;
        if (text_q.size() == 0) begin
          $error("unexpected beat: char_code %0d last %0b", char_code_o, last_o);
          err_cnt++;
        end else begin
          want = text_q.pop_front();
          if (char_code_o !== want.code) begin
            $error("char_code: expected %0d, got %0d", want.code, char_code_o);
            err_cnt++;
          end
          if (last_o !== want.is_last) begin
            $error("last: expected %0b, got %0b", want.is_last, last_o);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    // Extremes, zero, digit boundaries and embedded zeros.
    add_number(64'sd0, 1'b0);
    add_number(64'sd1, 1'b0);
    add_number(-64'sd1, 1'b0);
    add_number(64'sd9, 1'b0);
    add_number(64'sd10, 1'b0);
    add_number(-64'sd10, 1'b0);
    add_number(64'sd99, 1'b0);
    add_number(64'sd100, 1'b0);
    add_number(64'sd1000000007, 1'b0);
    add_number(64'sh7fff_ffff_ffff_ffff, 1'b0);
    add_number(64'sh8000_0000_0000_0000, 1'b0);
    add_number(64'sh8000_0000_0000_0001, 1'b0);
    add_number(64'sd1000000000000000000, 1'b0);
    add_number(64'sd999999999999999999, 1'b0);
    add_number(-64'sd1000000000000000000, 1'b0);
    add_number(-64'sd5000000000000000000, 1'b0);
    add_number(64'sh5555_5555_5555_5555, 1'b0);
    add_number(64'shaaaa_aaaa_aaaa_aaaa, 1'b0);
    for (int i = 0; i < RandomNums; i++) begin
      // The first random number and one in the middle wait for a full drain.
      add_number(random_number(), i == 0 || i == RandomNums / 2);
    end

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    while (numbers_q.size() != 0 || text_q.size() != 0) begin
      @(negedge clk_i);
    end
    // Room for any stray beat to show up.
    repeat (60) @(negedge clk_i);

    $display("Converted %0d numbers (%0d negative) into %0d characters, longest text %0d.",
             taken_cnt, neg_cnt, char_cnt, longest_text);
    $display("Input side was held off by full_o for %0d cycles.", full_cycles);
    if (err_cnt == 0 && text_q.size() == 0) begin
      $display("signed_binary_to_decimal_ascii test passed");
    end else begin
      $display("signed_binary_to_decimal_ascii test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/sbda_pkg.sv
src/sbda_front.sv
src/sbda_conv.sv
src/sbda_emit.sv
src/signed_binary_to_decimal_ascii.sv
tb/testbench.sv
